// File: sv/rcca_pkg.sv
package rcca_pkg;

   localparam logic [1:0] ACT_INSERT   = 2'd0;
   localparam logic [1:0] ACT_RETRIEVE = 2'd1;
   localparam logic [1:0] ACT_ADD      = 2'd2;
   localparam logic [1:0] ACT_DROP     = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_UNKNOWN = 2'd1;
   localparam logic [1:0] ST_NOROOM  = 2'd2;
   localparam logic [1:0] ST_FULL    = 2'd3;

   localparam logic KIND_MOVE   = 1'b0;
   localparam logic KIND_ANSWER = 1'b1;

   // one table entry as held by a cell
   typedef struct packed {
      logic        valid;
      logic [15:0] handle;
      logic [15:0] base;
      logic [15:0] length;
      logic [15:0] refs;
   } entry_type;

   // command broadcast from the controller to every cell
   typedef struct packed {
      logic        lookup;   // register the handle match of each cell
      logic        bump;     // add a reference at the matched cell
      logic        drop;     // drop a reference at the matched cell
      logic        append;   // write the new entry into the first free cell
      logic        rotate;   // compaction step: cells shift down, cell 0 wraps to the top
      logic [15:0] handle;
      logic [15:0] base;
      logic [15:0] length;
   } cell_cmd_type;

endpackage

// File: sv/rcca_cell.sv
module rcca_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  rcca_pkg::cell_cmd_type  cmd,
   input  rcca_pkg::entry_type     upper,       // neighbour above
   input  logic                    lower_valid, // neighbour below is occupied
   input  logic                    rot_in_valid,
   input  rcca_pkg::entry_type     rot_in,      // wrap value for the rotation
   input  logic                    hit_upper,   // an entry below is being removed
   output rcca_pkg::entry_type     entry,
   output logic                    hit
);

   rcca_pkg::entry_type entry_ff, entry_in;
   logic                hit_ff, hit_in;
   logic                match;

   assign match = entry_ff.valid && (entry_ff.handle == cmd.handle);

   always_comb begin
      entry_in = entry_ff;
      hit_in   = hit_ff;
      if (cmd.lookup) begin
         hit_in = match;
      end
      if (cmd.bump && hit_ff) begin
         if (entry_ff.refs != 16'hFFFF) begin
            entry_in.refs = entry_ff.refs + 16'd1;
         end
      end
      if (cmd.drop) begin
         // a cell at or above a removed entry shifts down by one
         if (hit_ff && entry_ff.refs != 16'd1) begin
            entry_in.refs = entry_ff.refs - 16'd1;
         end else if (hit_ff || hit_upper) begin
            entry_in = upper;
         end
      end
      if (cmd.append && !entry_ff.valid && lower_valid) begin
         entry_in.valid  = 1'b1;
         entry_in.handle = cmd.handle;
         entry_in.base   = cmd.base;
         entry_in.length = cmd.length;
         entry_in.refs   = 16'd1;
      end
      if (cmd.rotate) begin
         entry_in = rot_in_valid ? rot_in : upper;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
         hit_ff         <= 1'b0;
      end else begin
         entry_ff.valid <= entry_in.valid;
         hit_ff         <= hit_in;
      end
      entry_ff.handle <= entry_in.handle;
      entry_ff.base   <= entry_in.base;
      entry_ff.length <= entry_in.length;
      entry_ff.refs   <= entry_in.refs;
   end

   assign entry = entry_ff;
   assign hit   = hit_ff;

endmodule

// File: sv/refcount_compacting_allocator_core.sv
// Reference counted compacting allocator. Entries live in a row of cells, packed
// from cell 0 in allocation order. A retrieve, add or drop first registers the
// handle match of each cell, then acts and answers. An insert that fits goes on
// to an allocate step. An insert that does not fit first compacts: the row
// rotates by one cell each cycle, cell 0 leaving at the bottom and re-entering
// at the top with its new base, and one move word is issued per live entry;
// compaction steps through every cell (MAX_OBJECTS) and then closes, and the
// rotation waits while a move word is held by a stalled consumer. The result
// word sits in an output register; a new request is taken the cycle after it
// has gone.
module refcount_compacting_allocator_core #(
   parameter int STORE_BYTES = 65536,
   parameter int MAX_OBJECTS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [15:0] req_request_size,
   input  logic [15:0] req_object_handle,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic [15:0] rsp_result_handle,
   output logic [15:0] rsp_object_address,
   output logic [15:0] rsp_move_source,
   output logic [15:0] rsp_move_length,
   output logic [1:0]  rsp_status,
   output logic        rsp_bank,
   output logic        rsp_last
);

   localparam int CW = $clog2(MAX_OBJECTS + 1);
   localparam logic [16:0] STORE = 17'(STORE_BYTES);

   typedef enum logic [3:0] {
      S_IDLE    = 4'b0001,
      S_ACT     = 4'b0010,
      S_COMPACT = 4'b0100,
      S_ALLOC   = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   rcca_pkg::entry_type    ent [MAX_OBJECTS];
   logic                   hit [MAX_OBJECTS];
   logic                   hit_below [MAX_OBJECTS];
   logic                   low_valid [MAX_OBJECTS];
   rcca_pkg::cell_cmd_type cmd;
   rcca_pkg::entry_type    wrap;
   rcca_pkg::entry_type    empty_ent;

   logic [1:0]  act_ff;
   logic [15:0] size_ff, handle_ff;
   logic [16:0] fill_ff, fill_in;
   logic [15:0] next_ff, next_in;
   logic        bank_ff, bank_in;
   logic [CW-1:0] live_ff, live_in;
   logic [CW-1:0] step_ff, step_in;
   logic [16:0] dst_ff, dst_in;

   logic        ov_ff, ov_in;
   logic        okind_ff, okind_in, olast_ff, olast_in, obank_ff, obank_in;
   logic [15:0] oh_ff, oh_in, oa_ff, oa_in, os_ff, os_in, ol_ff, ol_in;
   logic [1:0]  ost_ff, ost_in;

   logic        any_hit, out_free, fits, drop_shift;
   logic [15:0] hit_base, hit_refs;

   assign empty_ent  = '0;
   assign out_free   = !ov_ff || !rsp_stall;
   assign fits       = {1'b0, size_ff} < (STORE - fill_ff);
   // a drop at count one removes the entry and closes the gap
   assign drop_shift = (hit_refs == 16'd1);

   always_comb begin
      any_hit  = 1'b0;
      hit_base = '0;
      hit_refs = '0;
      for (int i = 0; i < MAX_OBJECTS; i++) begin
         if (hit[i]) begin
            any_hit  = 1'b1;
            hit_base = ent[i].base;
            hit_refs = ent[i].refs;
         end
      end
   end

   // wrap value re-entering at the top cell during compaction
   always_comb begin
      wrap      = ent[0];
      wrap.base = dst_ff[15:0];
   end

   // for a removal, cells below the hit keep; cells at and above take the upper
   // neighbour. Cells see "hit below" through this chain.
   for (genvar g = 0; g < MAX_OBJECTS; g++) begin : g_hb
      if (g == 0) begin : g_z
         assign hit_below[g] = 1'b0;
         assign low_valid[g] = 1'b1;
      end else begin : g_n
         assign hit_below[g] = hit_below[g-1] || hit[g-1];
         assign low_valid[g] = ent[g-1].valid;
      end
   end

   for (genvar g = 0; g < MAX_OBJECTS; g++) begin : g_cell
      if (g == MAX_OBJECTS - 1) begin : g_top
         rcca_cell u_cell (
            .clock(clock), .reset(reset), .cmd(cmd), .upper(empty_ent),
            .lower_valid(low_valid[g]),
            .rot_in_valid(1'b1),
            .rot_in(ent[0].valid ? wrap : empty_ent),
            .hit_upper(hit_below[g] && drop_shift), .entry(ent[g]), .hit(hit[g]));
      end else begin : g_mid
         rcca_cell u_cell (
            .clock(clock), .reset(reset), .cmd(cmd), .upper(ent[g+1]),
            .lower_valid(low_valid[g]),
            .rot_in_valid(1'b0), .rot_in(empty_ent),
            .hit_upper(hit_below[g] && drop_shift), .entry(ent[g]), .hit(hit[g]));
      end
   end

   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      next_in  = next_ff;
      bank_in  = bank_ff;
      live_in  = live_ff;
      step_in  = step_ff;
      dst_in   = dst_ff;
      cmd      = '0;
      cmd.handle = handle_ff;
      ov_in    = ov_ff && rsp_stall;
      okind_in = okind_ff; olast_in = olast_ff; obank_in = obank_ff;
      oh_in = oh_ff; oa_in = oa_ff; os_in = os_ff; ol_in = ol_ff; ost_in = ost_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid && !ov_ff) begin
               state_in = S_ACT;
            end
            cmd.lookup = 1'b1;
            cmd.handle = req_object_handle;
         end
         S_ACT: begin
            if (out_free) begin
               ov_in = 1'b1; okind_in = rcca_pkg::KIND_ANSWER; olast_in = 1'b1;
               obank_in = bank_ff; oh_in = handle_ff; oa_in = '0; os_in = '0;
               ol_in = '0; ost_in = rcca_pkg::ST_OK;
               state_in = S_IDLE;
               case (act_ff)
                  rcca_pkg::ACT_INSERT: begin
                     oh_in = '0;
                     if (size_ff == '0) begin
                        ost_in = rcca_pkg::ST_NOROOM;
                     end else if (!fits) begin
                        ov_in    = 1'b0;
                        bank_in  = !bank_ff;
                        step_in  = '0;
                        dst_in   = '0;
                        state_in = S_COMPACT;
                     end else begin
                        ov_in    = 1'b0;
                        state_in = S_ALLOC;
                     end
                  end
                  default: begin
                     if (handle_ff == '0 || !any_hit) begin
                        ost_in = rcca_pkg::ST_UNKNOWN;
                     end else if (act_ff == rcca_pkg::ACT_RETRIEVE) begin
                        oa_in = hit_base;
                     end else if (act_ff == rcca_pkg::ACT_ADD) begin
                        cmd.bump = 1'b1;
                     end else begin
                        cmd.drop = 1'b1;
                        if (hit_refs == 16'd1) begin
                           live_in = live_ff - CW'(1);
                        end
                     end
                  end
               endcase
            end
         end
         S_COMPACT: begin
            if (step_ff == CW'(MAX_OBJECTS)) begin
               fill_in  = dst_ff;
               state_in = S_ALLOC;
            end else if (!ent[0].valid) begin
               cmd.rotate = 1'b1;
               step_in    = step_ff + CW'(1);
            end else if (out_free) begin
               cmd.rotate = 1'b1;
               step_in    = step_ff + CW'(1);
               dst_in     = dst_ff + {1'b0, ent[0].length};
               ov_in = 1'b1; okind_in = rcca_pkg::KIND_MOVE; olast_in = 1'b0;
               obank_in = bank_ff; oh_in = ent[0].handle; oa_in = dst_ff[15:0];
               os_in = ent[0].base; ol_in = ent[0].length; ost_in = rcca_pkg::ST_OK;
            end
         end
         S_ALLOC: begin
            if (out_free) begin
               ov_in = 1'b1; okind_in = rcca_pkg::KIND_ANSWER; olast_in = 1'b1;
               obank_in = bank_ff; oh_in = '0; oa_in = '0; os_in = '0; ol_in = '0;
               state_in = S_IDLE;
               if (!fits) begin
                  ost_in = rcca_pkg::ST_NOROOM;
               end else if (live_ff >= CW'(MAX_OBJECTS) || next_ff == '0) begin
                  ost_in = rcca_pkg::ST_FULL;
               end else begin
                  ost_in      = rcca_pkg::ST_OK;
                  oh_in       = next_ff;
                  oa_in       = fill_ff[15:0];
                  ol_in       = size_ff;
                  cmd.append  = 1'b1;
                  cmd.handle  = next_ff;
                  cmd.base    = fill_ff[15:0];
                  cmd.length  = size_ff;
                  fill_in     = fill_ff + {1'b0, size_ff};
                  next_in     = next_ff + 16'd1;
                  live_in     = live_ff + CW'(1);
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign req_stall = (state_ff != S_IDLE) || ov_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fill_ff  <= '0;
         next_ff  <= 16'd1;
         bank_ff  <= 1'b0;
         live_ff  <= '0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         next_ff  <= next_in;
         bank_ff  <= bank_in;
         live_ff  <= live_in;
         ov_ff    <= ov_in;
      end
      step_ff  <= step_in;
      dst_ff   <= dst_in;
      okind_ff <= okind_in; olast_ff <= olast_in; obank_ff <= obank_in;
      oh_ff <= oh_in; oa_ff <= oa_in; os_ff <= os_in; ol_ff <= ol_in; ost_ff <= ost_in;
      if (state_ff == S_IDLE && req_valid && !ov_ff) begin
         act_ff    <= req_action;
         size_ff   <= req_request_size;
         handle_ff <= req_object_handle;
      end
   end

   assign rsp_valid          = ov_ff;
   assign rsp_kind           = okind_ff;
   assign rsp_result_handle  = oh_ff;
   assign rsp_object_address = oa_ff;
   assign rsp_move_source    = os_ff;
   assign rsp_move_length    = ol_ff;
   assign rsp_status         = ost_ff;
   assign rsp_bank           = obank_ff;
   assign rsp_last           = olast_ff;

endmodule

// File: dv/refcount_compacting_allocator_core_tb.sv
`timescale 1ns / 1ps

module refcount_compacting_allocator_core_tb;

   localparam int STORE_BYTES = 65536;
   localparam int MAX_OBJECTS = 32;

   // one request word
   typedef struct {
      logic [1:0]  action;
      logic [15:0] size;
      logic [15:0] handle;
   } req_word_type;

   // one result word
   typedef struct {
      logic        kind;
      logic [15:0] handle;
      logic [15:0] addr;
      logic [15:0] src;
      logic [15:0] len;
      logic [1:0]  status;
      logic        bank;
      logic        last;
   } rsp_word_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_action;
   logic [15:0] req_request_size;
   logic [15:0] req_object_handle;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_kind;
   logic [15:0] rsp_result_handle;
   logic [15:0] rsp_object_address;
   logic [15:0] rsp_move_source;
   logic [15:0] rsp_move_length;
   logic [1:0]  rsp_status;
   logic        rsp_bank;
   logic        rsp_last;

   refcount_compacting_allocator_core #(
      .STORE_BYTES(STORE_BYTES),
      .MAX_OBJECTS(MAX_OBJECTS)
   ) dut (.*);

   // clock, 2 ns period
   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // allocator mirror: packed table in allocation order
   logic        tbl_valid [MAX_OBJECTS];
   logic [15:0] tbl_handle[MAX_OBJECTS];
   logic [15:0] tbl_base  [MAX_OBJECTS];
   logic [15:0] tbl_len   [MAX_OBJECTS];
   logic [15:0] tbl_refs  [MAX_OBJECTS];
   logic [16:0] fill_ptr;
   logic [15:0] next_hdl;
   logic        cur_bank;

   req_word_type pending_reqs[$];
   rsp_word_type expected_rsps[$];
   int           mismatches = 0;
   int           long_hold = 0;   // cycles left of the long receiver hold-off
   bit           req_taken = 1'b0;

   function automatic rsp_word_type mk_rsp(logic k, logic [15:0] h, logic [15:0] a,
                                           logic [15:0] s, logic [15:0] l,
                                           logic [1:0] st, logic lst);
      rsp_word_type r;
      r.kind = k; r.handle = h; r.addr = a; r.src = s; r.len = l;
      r.status = st; r.bank = cur_bank; r.last = lst;
      return r;
   endfunction

   function automatic void mirror_reset();
      for (int i = 0; i < MAX_OBJECTS; i++) begin
         tbl_valid[i] = 1'b0; tbl_handle[i] = '0; tbl_base[i] = '0;
         tbl_len[i] = '0; tbl_refs[i] = '0;
      end
      fill_ptr = '0;
      next_hdl = 16'd1;
      cur_bank = 1'b0;
   endfunction

   function automatic int find_entry(logic [15:0] h);
      if (h == 16'd0) return -1;
      for (int i = 0; i < MAX_OBJECTS; i++)
         if (tbl_valid[i] && tbl_handle[i] == h) return i;
      return -1;
   endfunction

   // works out every result word caused by one accepted request
   function automatic void predict_allocator(req_word_type q);
      int idx;
      int n;
      logic [16:0] dst;
      if (q.action == rcca_pkg::ACT_INSERT) begin
         if (q.size == 16'd0) begin
            expected_rsps.push_back(mk_rsp(rcca_pkg::KIND_ANSWER, 16'd0, 16'd0, 16'd0,
                                           16'd0, rcca_pkg::ST_NOROOM, 1'b1));
            return;
         end
         if (32'(q.size) >= STORE_BYTES - 32'(fill_ptr)) begin
            // compaction: flip bank, pack live entries from 0
            cur_bank = ~cur_bank;
            dst = '0;
            for (int i = 0; i < MAX_OBJECTS; i++) begin
               if (!tbl_valid[i]) continue;
               expected_rsps.push_back(mk_rsp(rcca_pkg::KIND_MOVE, tbl_handle[i],
                                              dst[15:0], tbl_base[i], tbl_len[i],
                                              rcca_pkg::ST_OK, 1'b0));
               tbl_base[i] = dst[15:0];
               dst = dst + {1'b0, tbl_len[i]};
            end
            fill_ptr = dst;
         end
         if (32'(q.size) >= STORE_BYTES - 32'(fill_ptr)) begin
            expected_rsps.push_back(mk_rsp(rcca_pkg::KIND_ANSWER, 16'd0, 16'd0, 16'd0,
                                           16'd0, rcca_pkg::ST_NOROOM, 1'b1));
            return;
         end
         n = 0;
         for (int i = 0; i < MAX_OBJECTS; i++) if (tbl_valid[i]) n++;
         if (n >= MAX_OBJECTS || next_hdl == 16'd0) begin
            expected_rsps.push_back(mk_rsp(rcca_pkg::KIND_ANSWER, 16'd0, 16'd0, 16'd0,
                                           16'd0, rcca_pkg::ST_FULL, 1'b1));
            return;
         end
         tbl_valid[n] = 1'b1; tbl_handle[n] = next_hdl;
         tbl_base[n] = fill_ptr[15:0]; tbl_len[n] = q.size; tbl_refs[n] = 16'd1;
         expected_rsps.push_back(mk_rsp(rcca_pkg::KIND_ANSWER, next_hdl, fill_ptr[15:0],
                                        16'd0, q.size, rcca_pkg::ST_OK, 1'b1));
         fill_ptr = fill_ptr + {1'b0, q.size};
         next_hdl = next_hdl + 16'd1;
         return;
      end
      idx = find_entry(q.handle);
      if (idx < 0) begin
         expected_rsps.push_back(mk_rsp(rcca_pkg::KIND_ANSWER, q.handle, 16'd0, 16'd0,
                                        16'd0, rcca_pkg::ST_UNKNOWN, 1'b1));
         return;
      end
      case (q.action)
         rcca_pkg::ACT_RETRIEVE: begin
            expected_rsps.push_back(mk_rsp(rcca_pkg::KIND_ANSWER, q.handle, tbl_base[idx],
                                           16'd0, 16'd0, rcca_pkg::ST_OK, 1'b1));
         end
         rcca_pkg::ACT_ADD: begin
            if (tbl_refs[idx] != 16'hFFFF) tbl_refs[idx]++;
            expected_rsps.push_back(mk_rsp(rcca_pkg::KIND_ANSWER, q.handle, 16'd0, 16'd0,
                                           16'd0, rcca_pkg::ST_OK, 1'b1));
         end
         default: begin
            tbl_refs[idx]--;
            if (tbl_refs[idx] == 16'd0) begin
               // close the gap, keeping allocation order
               for (int i = idx; i + 1 < MAX_OBJECTS; i++) begin
                  tbl_valid[i] = tbl_valid[i+1]; tbl_handle[i] = tbl_handle[i+1];
                  tbl_base[i] = tbl_base[i+1]; tbl_len[i] = tbl_len[i+1];
                  tbl_refs[i] = tbl_refs[i+1];
               end
               tbl_valid[MAX_OBJECTS-1] = 1'b0;
            end
            expected_rsps.push_back(mk_rsp(rcca_pkg::KIND_ANSWER, q.handle, 16'd0, 16'd0,
                                           16'd0, rcca_pkg::ST_OK, 1'b1));
         end
      endcase
   endfunction

   // driver: bursts of random length, random gaps; changes on falling edge
   int burst_left = 0;
   int gap_left = 0;
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // hold the stalled word
      end else begin
         if (req_taken) void'(pending_reqs.pop_front());
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            req_word_type nx;
            nx = pending_reqs[0];
            req_valid         <= 1'b1;
            req_action        <= nx.action;
            req_request_size  <= nx.size;
            req_object_handle <= nx.handle;
            if (burst_left > 0) burst_left--;
            else begin
               burst_left = $urandom_range(0, 12);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 5);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // the word is consumed at the rising edge; predict there
   always @(posedge clock) begin
      req_taken = !reset && req_valid && !req_stall;
      if (req_taken) begin
         req_word_type q;
         q.action = req_action; q.size = req_request_size; q.handle = req_object_handle;
         predict_allocator(q);
      end
   end

   // receiver stall pattern plus one long hold-off
   int stall_phase = 0;
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (long_hold > 0) begin
         long_hold--;
         rsp_stall <= 1'b1;
      end else begin
         stall_phase++;
         if (stall_phase == 40) long_hold = 300;
         if ((stall_phase / 64) % 3 == 0) rsp_stall <= 1'b0;   // quiet stretch
         else rsp_stall <= ($urandom_range(0, 3) == 0);
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_word_type e;
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result word, handle %0d", rsp_result_handle);
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_kind !== e.kind || rsp_result_handle !== e.handle ||
                rsp_object_address !== e.addr || rsp_move_source !== e.src ||
                rsp_move_length !== e.len || rsp_status !== e.status ||
                rsp_bank !== e.bank || rsp_last !== e.last) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch exp k%0d h%0d a%0d s%0d l%0d st%0d b%0d z%0d",
                     e.kind, e.handle, e.addr, e.src, e.len, e.status, e.bank, e.last);
                  $display("         got k%0d h%0d a%0d s%0d l%0d st%0d b%0d z%0d",
                     rsp_kind, rsp_result_handle, rsp_object_address, rsp_move_source,
                     rsp_move_length, rsp_status, rsp_bank, rsp_last);
               end
            end
         end
      end
   end

   function automatic void queue_req(logic [1:0] a, logic [15:0] s, logic [15:0] h);
      req_word_type q;
      q.action = a; q.size = s; q.handle = h;
      pending_reqs.push_back(q);
   endfunction

   // small handles mostly hit live entries; the rest is noise
   function automatic logic [15:0] pick_handle(int issued);
      case ($urandom_range(0, 9))
         0: return 16'(0);
         1: return 16'($urandom);
         default: return 16'($urandom_range(1, issued + 2));
      endcase
   endfunction

   function automatic logic [15:0] pick_size();
      case ($urandom_range(0, 19))
         0: return 16'($urandom);
         1: return 16'hFFFF;
         2: return 16'(0);
         3: return 16'($urandom_range(4096, 20000));
         default: return 16'($urandom_range(1, 600));
      endcase
   endfunction

   initial begin
      int issued;
      int wait_cyc;
      mirror_reset();
      reset = 1'b1;
      repeat (6) @(posedge clock);
      #0.5 reset = 1'b0;

      // directed part
      queue_req(rcca_pkg::ACT_INSERT, 16'd0, 16'd0);        // zero size
      queue_req(rcca_pkg::ACT_RETRIEVE, 16'd0, 16'd0);      // null handle
      queue_req(rcca_pkg::ACT_INSERT, 16'hFFFF, 16'd0);     // takes almost the whole store
      queue_req(rcca_pkg::ACT_INSERT, 16'd100, 16'hFFFF);
      queue_req(rcca_pkg::ACT_INSERT, 16'd200, 16'd0);
      queue_req(rcca_pkg::ACT_RETRIEVE, 16'd0, 16'd2);
      queue_req(rcca_pkg::ACT_ADD, 16'hFFFF, 16'd1);
      queue_req(rcca_pkg::ACT_DROP, 16'd0, 16'd1);
      queue_req(rcca_pkg::ACT_DROP, 16'd0, 16'd1);          // entry removed, bytes stay
      queue_req(rcca_pkg::ACT_RETRIEVE, 16'd0, 16'd1);      // now unknown
      queue_req(rcca_pkg::ACT_ADD, 16'd0, 16'hFFFF);        // unknown
      queue_req(rcca_pkg::ACT_INSERT, 16'hFF00, 16'd0);     // compacts
      queue_req(rcca_pkg::ACT_INSERT, 16'hFF00, 16'd0);     // no room even after compaction
      queue_req(rcca_pkg::ACT_RETRIEVE, 16'd0, 16'd4);
      issued = 4;

      // words offered while the receiver holds off
      for (int i = 0; i < 8; i++)
         queue_req(rcca_pkg::ACT_RETRIEVE, 16'd0, 16'($urandom_range(0, 5)));

      // queue more inserts than the table has cells; full status shows if the store has room
      for (int i = 0; i < MAX_OBJECTS + 2; i++) begin
         queue_req(rcca_pkg::ACT_INSERT, 16'($urandom_range(1, 64)), 16'($urandom));
         issued++;
      end

      // random part: mostly live-handle traffic with inserts keeping the table busy
      for (int i = 0; i < 440; i++) begin
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               queue_req(rcca_pkg::ACT_INSERT, pick_size(), 16'($urandom));
               issued++;
            end
            3, 4: queue_req(rcca_pkg::ACT_RETRIEVE, 16'($urandom), pick_handle(issued));
            5: queue_req(rcca_pkg::ACT_ADD, 16'($urandom), pick_handle(issued));
            default: queue_req(rcca_pkg::ACT_DROP, 16'($urandom), pick_handle(issued));
         endcase
      end
      queue_req(rcca_pkg::ACT_INSERT, 16'h8000, 16'h8000);

      while (pending_reqs.size() > 0 || req_valid) @(posedge clock);
      while (expected_rsps.size() > 0) @(posedge clock);
      // allow for a compaction walk still in flight
      wait_cyc = 4 * MAX_OBJECTS;
      repeat (wait_cyc) @(posedge clock);
      if (mismatches == 0 && expected_rsps.size() == 0)
         $display("refcount_compacting_allocator_core verification clean");
      else
         $display("refcount_compacting_allocator_core verification failed");
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("refcount_compacting_allocator_core verification failed");
      $finish;
   end

endmodule

// File: filelist.f
sv/rcca_pkg.sv
sv/rcca_cell.sv
sv/refcount_compacting_allocator_core.sv
dv/refcount_compacting_allocator_core_tb.sv
